>>> src/bfa_pkg.sv
// shared constants and codes of the bitmap frame allocator
`default_nettype none

package bfa_pkg;

    // frames managed and bitmap geometry
    localparam int MAX_FRAMES = 4096;
    localparam int WORD_BITS  = 32;
    localparam int WORDS      = MAX_FRAMES / WORD_BITS;
    localparam int WADDR_W    = $clog2(WORDS);
    localparam int BIT_W      = $clog2(WORD_BITS);
    localparam int IDX_W      = WADDR_W + BIT_W;
    localparam int CNT_W      = 13;
    localparam int CMD_W      = 2;
    localparam int ST_W       = 2;
    localparam int S_DATA_W   = 16;
    localparam int M_DATA_W   = 32;

    localparam logic [CNT_W-1:0] MAX_FRAMES_C = CNT_W'(MAX_FRAMES);
    localparam logic [CNT_W-1:0] CNT_MAX      = {CNT_W{1'b1}};

    // command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_INIT  = 2'd0,
        CMD_ALLOC = 2'd1,
        CMD_FREE  = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    // result status codes
    typedef enum logic [ST_W-1:0] {
        ST_OK    = 2'd0,
        ST_OOM   = 2'd1,
        ST_RANGE = 2'd2
    } status_t;

    // configuration register indexes
    localparam logic CFG_FRAME_COUNT = 1'b0;
    localparam logic CFG_RESERVED    = 1'b1;

endpackage

`default_nettype wire

>>> src/bitmap_frame_allocator.sv
// bitmap first-fit page-frame allocator with a word-wide bitmap memory
//
// Input transactions on s_tvalid/s_tready/s_tdata carry a command (init,
// alloc, free) and a frame index. Each command gives exactly one result
// transaction on m_tvalid/m_tready/m_tdata with the allocated index, a
// status and the current free-frame count.
// The used bitmap sits in a 128 x 32 memory with a registered read;
// each row has a valid bit that reset clears, so an unwritten row reads as
// all used. Reset leaves every frame used and the used count at 4096.
// Steps per command, with the memory walked one word a cycle:
//   init  : writes all 128 rows in order, then gives its result
//   alloc : reads rows in order up to the first free bit and sets it, else OOM
//   free  : reads the row, clears the bit, writes it back; skipped if out of range or unused command
// One command is in work at a time. The result goes to an output register,
// so a new command is accepted while the previous result waits; a command
// that finishes while the receiver still stalls holds until the register
// frees up. Configuration is written through cfg_we/cfg_addr/cfg_wdata
// while the block is idle; the user must keep to this, the block does not enforce it.
`default_nettype none

module bitmap_frame_allocator
    import bfa_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // configuration write port
    input  wire logic                 cfg_we,
    input  wire logic                 cfg_addr,
    input  wire logic [CNT_W-1:0]     cfg_wdata,
    // command stream
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_DATA_W-1:0]  s_tdata,  // command[1:0], frame_index[13:2], zeros
    // result stream
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_DATA_W-1:0]       m_tdata   // alloc_index[11:0], status[13:12],
                                                // free_count[26:14], zeros
);

    typedef enum logic [5:0] {
        S_IDLE    = 6'b000001,
        S_INIT    = 6'b000010,
        S_SCAN    = 6'b000100,
        S_FREE_RD = 6'b001000,
        S_FREE_WR = 6'b010000,
        S_RESP    = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    // configuration registers
    logic [CNT_W-1:0] frame_count_reg;
    logic [CNT_W-1:0] reserved_reg;

    // work registers
    logic [CNT_W-1:0]   used_cnt_reg, used_cnt_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [IDX_W-1:0]   alloc_reg, alloc_next;
    status_t            status_reg, status_next;
    logic [WADDR_W:0]   wcnt_reg, wcnt_next;
    logic [WADDR_W-1:0] chk_addr_reg, chk_addr_next;
    logic               pend_reg, pend_next;

    // output register
    logic                m_tvalid_reg;
    logic [M_DATA_W-1:0] m_tdata_reg;

    // bitmap memory and row valid bits
    logic [WORD_BITS-1:0] mem [WORDS];
    logic [WORD_BITS-1:0] mem_q;
    logic                 vld_q;
    logic [WORDS-1:0]     vld_reg;
    logic                 mem_we;
    logic [WADDR_W-1:0]   mem_waddr;
    logic [WORD_BITS-1:0] mem_wdata;
    logic                 mem_re;
    logic [WADDR_W-1:0]   mem_raddr;
    logic [WORD_BITS-1:0] rd_word;

    logic             s_fire;
    logic             out_free;
    logic [CNT_W-1:0] eff_n;
    logic [CNT_W-1:0] eff_res;
    logic [CNT_W-1:0] free_cnt;
    logic [CMD_W-1:0] in_cmd;
    logic [IDX_W-1:0] in_idx;

    logic [WORD_BITS-1:0] init_word;
    logic [WORD_BITS-1:0] free_mask;
    logic                 found;
    logic [BIT_W-1:0]     found_bit;

    assign in_cmd   = s_tdata[CMD_W-1:0];
    assign in_idx   = s_tdata[CMD_W +: IDX_W];
    assign s_tready = (state_reg == S_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // effective frame count and reserved frames
    assign eff_n    = (frame_count_reg > MAX_FRAMES_C) ? MAX_FRAMES_C : frame_count_reg;
    assign eff_res  = (reserved_reg > eff_n) ? eff_n : reserved_reg;
    assign free_cnt = (eff_n > used_cnt_reg) ? (eff_n - used_cnt_reg) : '0;

    // unwritten rows read as all used
    assign rd_word = vld_q ? mem_q : {WORD_BITS{1'b1}};

    // init pattern of the row being written
    always_comb begin
        logic [CNT_W-1:0] fi;
        for (int b = 0; b < WORD_BITS; b++) begin
            fi = CNT_W'({wcnt_reg[WADDR_W-1:0], BIT_W'(b)});
            init_word[b] = (fi < eff_res) || (fi >= eff_n);
        end
    end

    // free bits below the frame count in the checked row
    always_comb begin
        logic [CNT_W-1:0] fi;
        for (int b = 0; b < WORD_BITS; b++) begin
            fi = CNT_W'({chk_addr_reg, BIT_W'(b)});
            free_mask[b] = !rd_word[b] && (fi < eff_n);
        end
    end

    // lowest free bit
    always_comb begin
        found     = 1'b0;
        found_bit = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--) begin
            if (free_mask[b]) begin
                found     = 1'b1;
                found_bit = BIT_W'(b);
            end
        end
    end

    // command sequencer
    always_comb begin
        state_next    = state_reg;
        used_cnt_next = used_cnt_reg;
        idx_next      = idx_reg;
        alloc_next    = alloc_reg;
        status_next   = status_reg;
        wcnt_next     = wcnt_reg;
        chk_addr_next = chk_addr_reg;
        pend_next     = 1'b0;
        mem_we        = 1'b0;
        mem_waddr     = '0;
        mem_wdata     = '0;
        mem_re        = 1'b0;
        mem_raddr     = '0;
        case (state_reg)
            S_IDLE: begin
                if (s_fire) begin
                    idx_next    = in_idx;
                    alloc_next  = '0;
                    status_next = ST_OK;
                    wcnt_next   = '0;
                    case (in_cmd)
                        CMD_INIT:  state_next = S_INIT;
                        CMD_ALLOC: state_next = S_SCAN;
                        CMD_FREE: begin
                            if ({1'b0, in_idx} >= eff_n) begin
                                status_next = ST_RANGE;
                                state_next  = S_RESP;
                            end else begin
                                state_next = S_FREE_RD;
                            end
                        end
                        default: state_next = S_RESP;
                    endcase
                end
            end
            S_INIT: begin
                mem_we    = 1'b1;
                mem_waddr = wcnt_reg[WADDR_W-1:0];
                mem_wdata = init_word;
                wcnt_next = wcnt_reg + 1'b1;
                if (wcnt_reg[WADDR_W-1:0] == WADDR_W'(WORDS - 1)) begin
                    used_cnt_next = eff_res;
                    state_next    = S_RESP;
                end
            end
            S_SCAN: begin
                if (pend_reg && found) begin
                    mem_we      = 1'b1;
                    mem_waddr   = chk_addr_reg;
                    mem_wdata   = rd_word | (WORD_BITS'(1) << found_bit);
                    alloc_next  = {chk_addr_reg, found_bit};
                    status_next = ST_OK;
                    if (used_cnt_reg != CNT_MAX) begin
                        used_cnt_next = used_cnt_reg + 1'b1;
                    end
                    state_next = S_RESP;
                end else if (pend_reg && chk_addr_reg == WADDR_W'(WORDS - 1)) begin
                    status_next = ST_OOM;
                    state_next  = S_RESP;
                end else if (!wcnt_reg[WADDR_W]) begin
                    // issue the next row read
                    mem_re        = 1'b1;
                    mem_raddr     = wcnt_reg[WADDR_W-1:0];
                    chk_addr_next = wcnt_reg[WADDR_W-1:0];
                    pend_next     = 1'b1;
                    wcnt_next     = wcnt_reg + 1'b1;
                end
            end
            S_FREE_RD: begin
                mem_re     = 1'b1;
                mem_raddr  = idx_reg[IDX_W-1:BIT_W];
                state_next = S_FREE_WR;
            end
            S_FREE_WR: begin
                mem_we    = 1'b1;
                mem_waddr = idx_reg[IDX_W-1:BIT_W];
                mem_wdata = rd_word & ~(WORD_BITS'(1) << idx_reg[BIT_W-1:0]);
                if (used_cnt_reg != '0) begin
                    used_cnt_next = used_cnt_reg - 1'b1;
                end
                state_next = S_RESP;
            end
            S_RESP: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            frame_count_reg <= MAX_FRAMES_C;
            reserved_reg    <= '0;
            used_cnt_reg    <= MAX_FRAMES_C;
            pend_reg        <= 1'b0;
            m_tvalid_reg    <= 1'b0;
            vld_reg         <= '0;
        end else begin
            state_reg    <= state_next;
            used_cnt_reg <= used_cnt_next;
            pend_reg     <= pend_next;
            if (cfg_we) begin
                case (cfg_addr)
                    CFG_FRAME_COUNT: frame_count_reg <= cfg_wdata;
                    CFG_RESERVED:    reserved_reg    <= cfg_wdata;
                    default:         reserved_reg    <= reserved_reg;
                endcase
            end
            if (mem_we) begin
                vld_reg[mem_waddr] <= 1'b1;
            end
            if (state_reg == S_RESP && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        idx_reg      <= idx_next;
        alloc_reg    <= alloc_next;
        status_reg   <= status_next;
        wcnt_reg     <= wcnt_next;
        chk_addr_reg <= chk_addr_next;
        if (state_reg == S_RESP && out_free) begin
            m_tdata_reg <= {{(M_DATA_W - CNT_W - ST_W - IDX_W){1'b0}},
                            free_cnt, status_reg, alloc_reg};
        end
    end

    // bitmap memory
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            mem_q <= mem[mem_raddr];
            vld_q <= vld_reg[mem_raddr];
        end
    end

endmodule

`default_nettype wire

>>> sim/testbench.sv
// self-checking testbench for the bitmap first-fit frame allocator
`timescale 1ns / 1ps

module testbench;
    import bfa_pkg::*;

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_we;
    logic                 cfg_addr;
    logic [CNT_W-1:0]     cfg_wdata;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_DATA_W-1:0]  s_tdata;   // command[1:0], frame_index[13:2], zeros
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_DATA_W-1:0]  m_tdata;   // alloc_index[11:0], status[13:12],
                                     // free_count[26:14], zeros

    // one allocator answer
    typedef struct {
        logic [11:0]      frame;
        logic [ST_W-1:0]  status;
        logic [CNT_W-1:0] free_left;
    } alloc_result_t;

    // frame bitmap model and queue of answers still to come
    class alloc_scoreboard;
        bit            used_map[MAX_FRAMES];
        int unsigned   used_cnt;
        int unsigned   frame_count_reg;
        int unsigned   reserved_reg;
        alloc_result_t answers_q[$];
        int            errors;

        function new();
            foreach (used_map[i]) used_map[i] = 1'b1;
            used_cnt        = MAX_FRAMES;
            frame_count_reg = MAX_FRAMES;
            reserved_reg    = 0;
            errors          = 0;
        endfunction

        function void set_reg(logic addr, logic [CNT_W-1:0] value);
            if (addr == CFG_FRAME_COUNT)
                frame_count_reg = value;
            else
                reserved_reg = value;
        endfunction

        // apply one accepted command to the bitmap and queue its answer
        function void note_command(cmd_t cmd, logic [11:0] idx);
            int unsigned   n;
            int unsigned   res;
            int unsigned   i;
            bit            found;
            alloc_result_t r;
            n = (frame_count_reg > MAX_FRAMES) ? MAX_FRAMES : frame_count_reg;
            r.frame  = '0;
            r.status = ST_OK;
            case (cmd)
                CMD_INIT: begin
                    res = (reserved_reg > n) ? n : reserved_reg;
                    for (i = 0; i < MAX_FRAMES; i++)
                        used_map[i] = (i < res) || (i >= n);
                    used_cnt = res;
                end
                CMD_ALLOC: begin
                    r.status = ST_OOM;
                    found = 1'b0;
                    for (i = 0; i < n && !found; i++) begin
                        if (!used_map[i]) begin
                            used_map[i] = 1'b1;
                            if (used_cnt < CNT_MAX)
                                used_cnt++;
                            r.frame  = i[11:0];
                            r.status = ST_OK;
                            found    = 1'b1;
                        end
                    end
                end
                CMD_FREE: begin
                    if (idx >= n) begin
                        r.status = ST_RANGE;
                    end else begin
                        used_map[idx] = 1'b0;
                        if (used_cnt > 0)
                            used_cnt--;
                    end
                end
                default: ;
            endcase
            r.free_left = (n > used_cnt) ? CNT_W'(n - used_cnt) : '0;
            answers_q.push_back(r);
        endfunction

        function void flag(string what, int unsigned exp_v, int unsigned act_v);
            errors++;
            if (errors <= 10)
                $display("%0t: %s mismatch: expected %0d, got %0d", $realtime, what,
                         exp_v, act_v);
        endfunction

        // compare one result transaction with the oldest queued answer
        function void check_result(logic [M_DATA_W-1:0] data);
            alloc_result_t e;
            if (answers_q.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("%0t: result with none pending, data 0x%08h", $realtime, data);
                return;
            end
            e = answers_q.pop_front();
            if (data[11:0] !== e.frame)
                flag("alloc_index", e.frame, data[11:0]);
            if (data[13:12] !== e.status)
                flag("status", e.status, data[13:12]);
            if (data[26:14] !== e.free_left)
                flag("free_count", e.free_left, data[26:14]);
            if (data[31:27] !== 5'd0)
                flag("padding", 0, data[31:27]);
        endfunction

        function int pending();
            return answers_q.size();
        endfunction
    endclass

    alloc_scoreboard sb = new();
    int              burst_left;
    bit              long_hold_req;

    bitmap_frame_allocator DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // run limit
    initial begin
        #10_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // result monitor
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata);
    end

    // receiver: long hold-offs on request toggle, else stall windows of varying shape
    initial begin
        int         hold_cnt;
        int         mode;
        int         mode_left;
        logic [7:0] pat;
        bit         hold_seen;
        hold_cnt  = 0;
        mode      = 0;
        mode_left = 0;
        pat       = 8'hff;
        hold_seen = 1'b0;
        m_tready  = 1'b0;
        forever begin
            @(negedge aclk);
            if (long_hold_req != hold_seen) begin
                hold_seen = long_hold_req;
                hold_cnt  = $urandom_range(300, 500);
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                m_tready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = $urandom_range(0, 2);
                    mode_left = $urandom_range(16, 96);
                    pat       = 8'($urandom) | 8'h01;
                end
                mode_left--;
                case (mode)
                    0: m_tready <= 1'b1;
                    1: begin
                        m_tready <= pat[0];
                        pat = {pat[0], pat[7:1]};
                    end
                    default: m_tready <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    // offer one command and hold it until accepted
    task automatic send_cmd(cmd_t cmd, logic [11:0] idx);
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, idx, cmd};
        do @(posedge aclk); while (!s_tready);
        sb.note_command(cmd, idx);
    endtask

    // send a command inside a burst, with a random gap when the burst ends
    task automatic issue(cmd_t cmd, logic [11:0] idx);
        int gap;
        send_cmd(cmd, idx);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 6);
            @(negedge aclk);
            s_tvalid <= 1'b0;
            s_tdata  <= S_DATA_W'($urandom);
            repeat (gap - 1) @(negedge aclk);
            burst_left = $urandom_range(0, 30);
        end
    endtask

    // stop offering and wait until every answer has come back
    task automatic wait_idle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // write both registers while idle
    task automatic set_regs(logic [CNT_W-1:0] frames, logic [CNT_W-1:0] reserved);
        wait_idle();
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= CFG_FRAME_COUNT;
        cfg_wdata <= frames;
        @(negedge aclk);
        sb.set_reg(CFG_FRAME_COUNT, frames);
        cfg_addr  <= CFG_RESERVED;
        cfg_wdata <= reserved;
        @(negedge aclk);
        sb.set_reg(CFG_RESERVED, reserved);
        cfg_we    <= 1'b0;
    endtask

    // stimulus
    initial begin
        int               done_items;
        int               phase;
        int               n_items;
        int               k;
        int               eff;
        int               pick;
        logic [CNT_W-1:0] fc;
        logic [CNT_W-1:0] rf;
        logic [11:0]      idx;
        aresetn       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        cfg_we        = 1'b0;
        cfg_addr      = CFG_FRAME_COUNT;
        cfg_wdata     = '0;
        burst_left    = 0;
        long_hold_req = 1'b0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // after reset every frame is used
        issue(CMD_ALLOC, 12'd0);
        issue(CMD_FREE, 12'hfff);
        issue(CMD_FREE, 12'h000);
        issue(CMD_ALLOC, 12'h000);
        issue(CMD_ALLOC, 12'h000);
        issue(CMD_NONE, 12'hfff);
        issue(CMD_NONE, 12'h555);

        // eight frames, three reserved: fill up, range checks, double free
        set_regs(13'd8, 13'd3);
        issue(CMD_INIT, 12'h000);
        repeat (6) issue(CMD_ALLOC, 12'h000);
        issue(CMD_FREE, 12'd8);
        issue(CMD_FREE, 12'd7);
        issue(CMD_FREE, 12'd7);
        issue(CMD_FREE, 12'd0);
        issue(CMD_ALLOC, 12'h000);

        // no frames at all, reservation clamped
        set_regs(13'd0, CNT_MAX);
        issue(CMD_INIT, 12'h000);
        issue(CMD_ALLOC, 12'h000);
        issue(CMD_FREE, 12'h000);

        // count saturates at zero
        set_regs(13'd8, 13'd0);
        issue(CMD_INIT, 12'h000);
        issue(CMD_FREE, 12'd3);

        // random phases, each with its own register setting
        done_items = 0;
        phase      = 0;
        while (done_items < 900) begin
            case (phase)
                0: begin fc = MAX_FRAMES_C; rf = 13'd0; end
                1: begin fc = CNT_MAX; rf = CNT_MAX; end
                2: begin fc = 13'd1; rf = 13'd0; end
                3: begin fc = MAX_FRAMES_C; rf = 13'd4000; end
                default: begin
                    pick = $urandom_range(0, 9);
                    if (pick == 0)
                        fc = CNT_W'($urandom_range(0, 4096));
                    else if (pick <= 7)
                        fc = CNT_W'($urandom_range(1, 64));
                    else
                        fc = CNT_W'($urandom_range(65, 600));
                    rf = ($urandom_range(0, 3) == 0) ? 13'd0 :
                         CNT_W'($urandom_range(0, fc + 8));
                end
            endcase
            set_regs(fc, rf);
            eff = (fc > MAX_FRAMES) ? MAX_FRAMES : int'(fc);
            // now and then keep the old bitmap under a new frame count
            if (phase < 4 || $urandom_range(0, 7) != 0) begin
                issue(CMD_INIT, 12'($urandom));
                done_items++;
            end
            n_items = $urandom_range(30, 90);
            for (k = 0; k < n_items; k++) begin
                if (phase % 4 == 1 && k == 5)
                    long_hold_req = ~long_hold_req;
                pick = $urandom_range(0, 99);
                if (pick < 50) begin
                    issue(CMD_ALLOC, 12'($urandom));
                end else if (pick < 90) begin
                    if (eff == 0 || $urandom_range(0, 6) == 0)
                        idx = 12'($urandom_range(0, 4095));
                    else
                        idx = 12'($urandom_range(0, eff - 1));
                    issue(CMD_FREE, idx);
                end else if (pick < 95) begin
                    issue(CMD_INIT, 12'($urandom));
                end else begin
                    issue(CMD_NONE, 12'($urandom));
                end
                done_items++;
            end
            phase++;
        end

        // drain and let any stray result show up
        wait_idle();
        repeat (140) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            if (sb.pending() != 0)
                $display("%0d results never arrived", sb.pending());
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
